FILE: rtl/salc_pkg.sv
// Shared constants, codes and helpers of the set-associative LRU cache.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

	// build defaults
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int TAG_WIDTH_DEF    = 32;

	// field widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 64;
	localparam int CNT_W   = 32;
	localparam int SB_CFG_W = 3;
	localparam int BB_CFG_W = 6;
	localparam int WY_CFG_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

	// register reset values
	localparam logic [SB_CFG_W-1:0] SET_BITS_RST   = 3'd1;
	localparam logic [BB_CFG_W-1:0] BLOCK_BITS_RST = 6'd1;
	localparam logic [WY_CFG_W-1:0] WAYS_RST       = 4'd1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// outcome of one lookup
	typedef struct packed {
		logic hit;
		logic evicted;
	} access_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/salc_tag_store.sv
// Set-organised line store: valid, tag and rank rows in one synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module salc_tag_store #(
	parameter int SET_W  = 6,
	parameter int WAYS   = 8,
	parameter int TAG_W  = 32,
	parameter int RANK_W = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [SET_W-1:0]              rd_set,
	output logic      [WAYS-1:0]               rd_valid,
	output logic      [WAYS-1:0][TAG_W-1:0]    rd_tag,
	output logic      [WAYS-1:0][RANK_W-1:0]   rd_rank,
	input  wire logic                          wr_en,
	input  wire logic [SET_W-1:0]              wr_set,
	input  wire logic [WAYS-1:0]               wr_valid,
	input  wire logic [WAYS-1:0][TAG_W-1:0]    wr_tag,
	input  wire logic [WAYS-1:0][RANK_W-1:0]   wr_rank
);
	localparam int DEPTH = 1 << SET_W;
	localparam int ROW_W = WAYS * (1 + TAG_W + RANK_W);
	localparam int TAG_LO = WAYS * RANK_W;

	logic [ROW_W-1:0] mem [DEPTH];
	logic [ROW_W-1:0] rd_row_q;
	logic             rd_init_q;
	logic [DEPTH-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= {wr_valid, wr_tag, wr_rank};
		end
		if (rd_en) begin
			rd_row_q  <= mem[rd_set];
			rd_init_q <= written_q[rd_set];
		end
	end

	// rows never written read as their reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_set] <= 1'b1;
		end
	end

	always_comb begin
		rd_tag = rd_row_q[TAG_LO + WAYS*TAG_W - 1 : TAG_LO];
		if (rd_init_q) begin
			rd_valid = rd_row_q[ROW_W-1 -: WAYS];
			rd_rank  = rd_row_q[TAG_LO-1:0];
		end else begin
			rd_valid = '0;
			for (int w = 0; w < WAYS; w++) begin
				rd_rank[w] = RANK_W'(w);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/salc_lru_update.sv
// Tag compare, victim pick and LRU rank update for one set.
`timescale 1ns / 1ps
`default_nettype none
module salc_lru_update #(
	parameter int WAYS   = 8,
	parameter int TAG_W  = 32,
	parameter int RANK_W = 3,
	parameter int WCNT_W = 4
) (
	input  wire logic [WAYS-1:0]             row_valid,
	input  wire logic [WAYS-1:0][TAG_W-1:0]  row_tag,
	input  wire logic [WAYS-1:0][RANK_W-1:0] row_rank,
	input  wire logic [TAG_W-1:0]            tag,
	input  wire logic [WCNT_W-1:0]           ways,
	output salc_pkg::access_res_t            res,
	output logic      [WAYS-1:0]             new_valid,
	output logic      [WAYS-1:0][TAG_W-1:0]  new_tag,
	output logic      [WAYS-1:0][RANK_W-1:0] new_rank
);
	import salc_pkg::*;

	logic [WAYS-1:0]   in_use;
	logic [WAYS-1:0]   match;
	logic [RANK_W-1:0] found;
	logic [RANK_W-1:0] victim;
	logic [RANK_W-1:0] target;
	logic [RANK_W-1:0] old_rank;
	logic              hit;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (w < int'(ways));
			match[w]  = in_use[w] && row_valid[w] && (row_tag[w] == tag);
		end

		// lowest matching way wins
		found = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				found = RANK_W'(w);
			end
		end
		hit = |match;

		// least recent used way, lowest way on a tie
		victim = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (in_use[w] && (row_rank[w] < row_rank[victim])) begin
				victim = RANK_W'(w);
			end
		end

		target   = hit ? found : victim;
		old_rank = row_rank[target];

		new_valid = row_valid;
		new_tag   = row_tag;
		new_rank  = row_rank;
		new_valid[target] = 1'b1;
		new_tag[target]   = tag;
		for (int w = 0; w < WAYS; w++) begin
			if (RANK_W'(w) == target) begin
				new_rank[w] = RANK_W'(ways - 1'b1);
			end else if (in_use[w] && (row_rank[w] > old_rank) && (row_rank[w] != '0)) begin
				new_rank[w] = row_rank[w] - 1'b1;
			end
		end

		res.hit     = hit;
		res.evicted = !hit && row_valid[victim];
	end

endmodule
`default_nettype wire

FILE: rtl/set_assoc_lru_cache_model.sv
// Top level of the set-associative cache with LRU replacement.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | op, address
//  out     | out_valid / out_stall | hit, evicted, hit_total, miss_total,
//          |                       | eviction_total, last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Steps: a load or store reads the set, then compares and writes back; a
// modify does a second compare and write back, working from the row written
// by the first.
// Reset: asynchronous, clears counters, control and the per-set written flags;
// an unwritten set reads as all lines invalid with ranks equal to way number.
// Stalls: a finished result sits in the output register; the next input is
// taken meanwhile, and the lookup holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
	parameter int TAG_WIDTH    = salc_pkg::TAG_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input items
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [salc_pkg::OP_W-1:0]        op,
	input  wire logic [salc_pkg::ADDR_W-1:0]      address,
	// results
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  hit,
	output logic                                  evicted,
	output logic      [salc_pkg::CNT_W-1:0]       hit_total,
	output logic      [salc_pkg::CNT_W-1:0]       miss_total,
	output logic      [salc_pkg::CNT_W-1:0]       eviction_total,
	output logic                                  last,
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import salc_pkg::*;

	localparam int SET_W  = MAX_SET_BITS;
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
	localparam int SHFT_W = 7;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	// configuration registers
	logic [SB_CFG_W-1:0] set_bits_q;
	logic [BB_CFG_W-1:0] block_bits_q;
	logic [WY_CFG_W-1:0] ways_q;

	logic state_q;
	logic modify_q;   // a second access follows this one
	logic fwd_sel_q;  // lookup works from the row just written

	logic [SET_W-1:0]     set_q;
	logic [TAG_WIDTH-1:0] tag_q;

	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 evicted_q;
	logic [CNT_W-1:0]     hit_total_q;
	logic [CNT_W-1:0]     miss_total_q;
	logic [CNT_W-1:0]     evict_total_q;
	logic                 last_q;

	// effective geometry
	logic [SB_W-1:0]   sb_eff;
	logic [WCNT_W-1:0] ways_eff;
	logic [SHFT_W-1:0] tag_shift;
	logic [ADDR_W-1:0] addr_shifted;
	logic [SET_W-1:0]  set_new;
	logic [TAG_WIDTH-1:0] tag_new;

	logic in_xfer;
	logic op_known;
	logic look_fire;

	// row paths
	logic [MAX_WAYS-1:0]                ram_valid;
	logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] ram_tag;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    ram_rank;
	logic [MAX_WAYS-1:0]                fwd_valid_q;
	logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] fwd_tag_q;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    fwd_rank_q;
	logic [MAX_WAYS-1:0]                cur_valid;
	logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] cur_tag;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    cur_rank;
	logic [MAX_WAYS-1:0]                upd_valid;
	logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] upd_tag;
	logic [MAX_WAYS-1:0][RANK_W-1:0]    upd_rank;
	access_res_t                        res;

	logic [CNT_W-1:0] hit_cnt_n;
	logic [CNT_W-1:0] miss_cnt_n;
	logic [CNT_W-1:0] evict_cnt_n;

	// configuration: the user makes writes arrive only while idle; the block leaves this unchecked and is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			block_bits_q <= BLOCK_BITS_RST;
			ways_q       <= WAYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SB_CFG_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BB_CFG_W-1:0];
				CFG_WAYS:       ways_q       <= cfg_data[WY_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// address split: offset, set index, tag
	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			sb_eff = SB_W'(MAX_SET_BITS);
		end else begin
			sb_eff = SB_W'(set_bits_q);
		end
		if (ways_q == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_q);
		end
		addr_shifted = address >> block_bits_q;
		set_new      = addr_shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
		tag_shift    = SHFT_W'(block_bits_q) + SHFT_W'(sb_eff);
		tag_new      = TAG_WIDTH'(address >> tag_shift);  // zero for shifts of 64 up
	end

	assign op_known  = (op == OP_LOAD) || (op == OP_STORE) || (op == OP_MODIFY);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign look_fire = (state_q == ST_LOOK) && (!out_valid_q || !out_stall);

	salc_tag_store #(
		.SET_W  (SET_W),
		.WAYS   (MAX_WAYS),
		.TAG_W  (TAG_WIDTH),
		.RANK_W (RANK_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_xfer && op_known),
		.rd_set   (set_new),
		.rd_valid (ram_valid),
		.rd_tag   (ram_tag),
		.rd_rank  (ram_rank),
		.wr_en    (look_fire),
		.wr_set   (set_q),
		.wr_valid (upd_valid),
		.wr_tag   (upd_tag),
		.wr_rank  (upd_rank)
	);

	// second access of a modify sees the first one's write-back directly
	always_comb begin
		if (fwd_sel_q) begin
			cur_valid = fwd_valid_q;
			cur_tag   = fwd_tag_q;
			cur_rank  = fwd_rank_q;
		end else begin
			cur_valid = ram_valid;
			cur_tag   = ram_tag;
			cur_rank  = ram_rank;
		end
	end

	salc_lru_update #(
		.WAYS   (MAX_WAYS),
		.TAG_W  (TAG_WIDTH),
		.RANK_W (RANK_W),
		.WCNT_W (WCNT_W)
	) u_lru (
		.row_valid (cur_valid),
		.row_tag   (cur_tag),
		.row_rank  (cur_rank),
		.tag       (tag_q),
		.ways      (ways_eff),
		.res       (res),
		.new_valid (upd_valid),
		.new_tag   (upd_tag),
		.new_rank  (upd_rank)
	);

	always_comb begin
		hit_cnt_n   = res.hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
		miss_cnt_n  = res.hit ? miss_cnt_q : sat_inc(miss_cnt_q);
		evict_cnt_n = res.evicted ? sat_inc(evict_cnt_q) : evict_cnt_q;
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modify_q    <= 1'b0;
			fwd_sel_q   <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded by a lookup, emptied by a transfer
			if (look_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && op_known) begin
						state_q   <= ST_LOOK;
						modify_q  <= (op == OP_MODIFY);
						fwd_sel_q <= 1'b0;
					end
				end
				ST_LOOK: begin
					if (look_fire) begin
						hit_cnt_q   <= hit_cnt_n;
						miss_cnt_q  <= miss_cnt_n;
						evict_cnt_q <= evict_cnt_n;
						if (modify_q) begin
							modify_q  <= 1'b0;
							fwd_sel_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			set_q <= set_new;
			tag_q <= tag_new;
		end
		if (look_fire) begin
			fwd_valid_q   <= upd_valid;
			fwd_tag_q     <= upd_tag;
			fwd_rank_q    <= upd_rank;
			hit_q         <= res.hit;
			evicted_q     <= res.evicted;
			hit_total_q   <= hit_cnt_n;
			miss_total_q  <= miss_cnt_n;
			evict_total_q <= evict_cnt_n;
			last_q        <= !modify_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign evicted        = evicted_q;
	assign hit_total      = hit_total_q;
	assign miss_total     = miss_total_q;
	assign eviction_total = evict_total_q;
	assign last           = last_q;

endmodule
`default_nettype wire
